### design/vdrm_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager package
// Shared types and codes for the split virtqueue descriptor ring producer.
// ----------------------------------------------------------------------------
`default_nettype none

package vdrm_pkg;

   // Configuration register indexes
   localparam int                CSR_INDEX_W        = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_ID       = 2'd1;

   // Request modes
   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_SEGMENT = 2'd1;
   localparam logic [1:0] MODE_USED    = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_DESC   = 3'd0;
   localparam logic [2:0] KIND_AVAIL  = 3'd1;
   localparam logic [2:0] KIND_NOTIFY = 3'd2;
   localparam logic [2:0] KIND_REJECT = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;
   localparam logic [2:0] KIND_ERROR  = 3'd5;

   // Descriptor flags
   localparam logic [1:0] FLAG_NEXT  = 2'b01;
   localparam logic [1:0] FLAG_WRITE = 2'b10;

   localparam logic [31:0] HEADER_SIZE = 32'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_AVAIL,
      ST_NOTIFY
   } state_type;

endpackage : vdrm_pkg

`default_nettype wire

### design/virtqueue_descriptor_ring_manager.sv
// ----------------------------------------------------------------------------
// Virtqueue descriptor ring manager
// Driver-side producer for a split virtqueue with in-order reclaim.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: a start (segment count), a buffer
//   segment (address, length) or a used ring entry from the device. rsp_*
//   returns the results: descriptor writes, the available ring write, the
//   queue notify, or a reject / completion / error. rsp_last marks the final
//   result of an item. csr_* writes header_address and queue_id; csr_ready is
//   always high and writes take effect on the next cycle.
//   An item is taken in ST_IDLE and executed in ST_EXEC; a final segment
//   adds ST_AVAIL and ST_NOTIFY for the avail write and the notify. The
//   chain length store is a synchronous memory, read continuously at the
//   oldest chain head, so a used entry needs no separate read state.
//   A new item is accepted while the last result still sits in the output
//   register. When rsp_stall is high the output register holds its result
//   and execution waits for it to drain.
//   Synchronous reset empties the ring (QUEUE_SIZE - 2 free descriptors),
//   clears the counters and the output valid flag; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module virtqueue_descriptor_ring_manager #(
   parameter int QUEUE_SIZE = 256
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [1:0]                       req_mode,
   input  wire  [7:0]                       req_segment_count,
   input  wire  [63:0]                      req_buffer_address,
   input  wire  [31:0]                      req_buffer_length,
   input  wire  [7:0]                       req_used_id,

   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [2:0]                       rsp_kind,
   output logic [7:0]                       rsp_slot,
   output logic [63:0]                      rsp_desc_address,
   output logic [31:0]                      rsp_desc_length,
   output logic [1:0]                       rsp_desc_flags,
   output logic [7:0]                       rsp_next_slot,
   output logic [7:0]                       rsp_ring_value,
   output logic [3:0]                       rsp_notify_queue,
   output logic [7:0]                       rsp_free_count,
   output logic                             rsp_last,

   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [vdrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [63:0]                      csr_data
);

   import vdrm_pkg::*;

   localparam int IDX_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
   localparam int SW    = ((IDX_W > 8) ? IDX_W : 8) + 1;
   localparam logic [SW-1:0]    QSIZE    = SW'(QUEUE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SIZE - 1);
   localparam logic [IDX_W-1:0] FREE_RST = IDX_W'(QUEUE_SIZE - 2);

   // Configuration
   logic [63:0]      header_address_ff;
   logic [3:0]       queue_id_ff;

   // Control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] next_free_ff, next_free_in;
   logic [IDX_W-1:0] oldest_head_ff, oldest_head_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic [15:0]      avail_idx_ff, avail_idx_in;
   logic [IDX_W-1:0] avail_slot_ff, avail_slot_in;
   logic             open_ff, open_in;
   logic [7:0]       seg_left_ff, seg_left_in;
   logic [7:0]       seg_pos_ff, seg_pos_in;

   // Captured request
   logic [1:0]       req_mode_ff;
   logic [7:0]       req_count_ff;
   logic [63:0]      req_addr_ff;
   logic [31:0]      req_len_ff;
   logic [7:0]       req_id_ff;

   // Chain length store
   logic [7:0]       chain_mem [QUEUE_SIZE];
   logic [7:0]       chain_rd_ff;
   logic             chain_we;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_slot_ff, rsp_slot_in;
   logic [63:0]      rsp_addr_ff, rsp_addr_in;
   logic [31:0]      rsp_len_ff, rsp_len_in;
   logic [1:0]       rsp_flags_ff, rsp_flags_in;
   logic [7:0]       rsp_next_ff, rsp_next_in;
   logic [7:0]       rsp_ring_ff, rsp_ring_in;
   logic [3:0]       rsp_nq_ff, rsp_nq_in;
   logic [7:0]       rsp_free_ff, rsp_free_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             out_load;
   logic             out_free;
   logic             req_take;

   // Index arithmetic
   logic [SW-1:0]    desc_sum;
   logic [IDX_W-1:0] desc_idx;
   logic [IDX_W-1:0] desc_nxt;
   logic [IDX_W-1:0] head_nxt;
   logic [SW-1:0]    rec_sum;
   logic [IDX_W-1:0] rec_idx;
   logic [IDX_W-1:0] free_after_start;
   logic [IDX_W-1:0] free_after_rec;
   logic             start_bad;
   logic             used_bad;
   logic             seg_final;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_address_ff <= '0;
         queue_id_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HEADER_ADDRESS) begin
            header_address_ff <= csr_data;
         end
         if (csr_index == CSR_QUEUE_ID) begin
            queue_id_ff <= csr_data[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_mode_ff  <= req_mode;
         req_count_ff <= req_segment_count;
         req_addr_ff  <= req_buffer_address;
         req_len_ff   <= req_buffer_length;
         req_id_ff    <= req_used_id;
      end
   end

   // Read the oldest chain head every cycle; writes never overlap a used entry
   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[next_free_ff] <= req_count_ff;
      end
      chain_rd_ff <= chain_mem[oldest_head_ff];
   end

   always_comb begin
      desc_sum = SW'(next_free_ff) + SW'(seg_pos_ff) + SW'(1);
      desc_idx = (desc_sum >= QSIZE) ? IDX_W'(desc_sum - QSIZE) : IDX_W'(desc_sum);
      desc_nxt = (desc_idx == LAST_IDX) ? '0 : desc_idx + IDX_W'(1);
      head_nxt = (next_free_ff == LAST_IDX) ? '0 : next_free_ff + IDX_W'(1);
      rec_sum  = SW'(oldest_head_ff) + SW'(chain_rd_ff) + SW'(1);
      rec_idx  = (rec_sum >= QSIZE) ? IDX_W'(rec_sum - QSIZE) : IDX_W'(rec_sum);
      free_after_start = free_ff - IDX_W'(req_count_ff) - IDX_W'(1);
      free_after_rec   = free_ff + IDX_W'(chain_rd_ff) + IDX_W'(1);
      start_bad = open_ff || (req_count_ff == 8'd0) ||
                  (SW'(free_ff) < SW'(req_count_ff) + SW'(1));
      used_bad  = (oldest_head_ff == next_free_ff) ||
                  (SW'(req_id_ff) != SW'(oldest_head_ff));
      seg_final = (seg_left_ff <= 8'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_free_ff   <= '0;
         oldest_head_ff <= '0;
         free_ff        <= FREE_RST;
         avail_idx_ff   <= '0;
         avail_slot_ff  <= '0;
         open_ff        <= 1'b0;
         seg_left_ff    <= '0;
         seg_pos_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_free_ff   <= next_free_in;
         oldest_head_ff <= oldest_head_in;
         free_ff        <= free_in;
         avail_idx_ff   <= avail_idx_in;
         avail_slot_ff  <= avail_slot_in;
         open_ff        <= open_in;
         seg_left_ff    <= seg_left_in;
         seg_pos_ff     <= seg_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_flags_ff <= rsp_flags_in;
         rsp_next_ff  <= rsp_next_in;
         rsp_ring_ff  <= rsp_ring_in;
         rsp_nq_ff    <= rsp_nq_in;
         rsp_free_ff  <= rsp_free_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      next_free_in   = next_free_ff;
      oldest_head_in = oldest_head_ff;
      free_in        = free_ff;
      avail_idx_in   = avail_idx_ff;
      avail_slot_in  = avail_slot_ff;
      open_in        = open_ff;
      seg_left_in    = seg_left_ff;
      seg_pos_in     = seg_pos_ff;
      chain_we       = 1'b0;
      out_load       = 1'b0;
      rsp_kind_in    = KIND_ERROR;
      rsp_slot_in    = '0;
      rsp_addr_in    = '0;
      rsp_len_in     = '0;
      rsp_flags_in   = '0;
      rsp_next_in    = '0;
      rsp_ring_in    = '0;
      rsp_nq_in      = '0;
      rsp_free_in    = 8'(free_ff);
      rsp_last_in    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            // hold until the output register can take a result
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               unique case (req_mode_ff)
                  MODE_START: begin
                     if (start_bad) begin
                        rsp_kind_in = KIND_REJECT;
                     end else begin
                        free_in      = free_after_start;
                        chain_we     = 1'b1;
                        open_in      = 1'b1;
                        seg_left_in  = req_count_ff;
                        seg_pos_in   = '0;
                        rsp_kind_in  = KIND_DESC;
                        rsp_slot_in  = 8'(next_free_ff);
                        rsp_addr_in  = header_address_ff;
                        rsp_len_in   = HEADER_SIZE;
                        rsp_flags_in = FLAG_NEXT;
                        rsp_next_in  = 8'(head_nxt);
                        rsp_free_in  = 8'(free_after_start);
                     end
                  end
                  MODE_SEGMENT: begin
                     if (open_ff) begin
                        seg_pos_in   = seg_pos_ff + 8'd1;
                        seg_left_in  = seg_left_ff - 8'd1;
                        rsp_kind_in  = KIND_DESC;
                        rsp_slot_in  = 8'(desc_idx);
                        rsp_addr_in  = req_addr_ff;
                        rsp_len_in   = req_len_ff;
                        rsp_flags_in = seg_final ? FLAG_WRITE : (FLAG_WRITE | FLAG_NEXT);
                        rsp_next_in  = 8'(desc_nxt);
                        rsp_last_in  = !seg_final;
                        if (seg_final) begin
                           state_in = ST_AVAIL;
                        end
                     end
                  end
                  MODE_USED: begin
                     if (!used_bad) begin
                        free_in        = free_after_rec;
                        oldest_head_in = rec_idx;
                        rsp_kind_in    = KIND_DONE;
                        rsp_slot_in    = 8'(oldest_head_ff);
                        rsp_free_in    = 8'(free_after_rec);
                     end
                  end
                  default: begin
                     rsp_kind_in = KIND_ERROR;
                  end
               endcase
            end
         end

         ST_AVAIL: begin
            if (out_free) begin
               out_load     = 1'b1;
               state_in     = ST_NOTIFY;
               rsp_kind_in  = KIND_AVAIL;
               rsp_slot_in  = 8'(avail_slot_ff);
               rsp_ring_in  = 8'(next_free_ff);
               rsp_last_in  = 1'b0;
               // segment position already counts the final segment here
               next_free_in = desc_idx;
               avail_idx_in = avail_idx_ff + 16'd1;
               if ((avail_slot_ff == LAST_IDX) || (avail_idx_ff == 16'hFFFF)) begin
                  avail_slot_in = '0;
               end else begin
                  avail_slot_in = avail_slot_ff + IDX_W'(1);
               end
               open_in     = 1'b0;
               seg_left_in = '0;
               seg_pos_in  = '0;
            end
         end

         ST_NOTIFY: begin
            if (out_free) begin
               out_load    = 1'b1;
               state_in    = ST_IDLE;
               rsp_kind_in = KIND_NOTIFY;
               rsp_nq_in   = queue_id_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_desc_address = rsp_addr_ff;
   assign rsp_desc_length  = rsp_len_ff;
   assign rsp_desc_flags   = rsp_flags_ff;
   assign rsp_next_slot    = rsp_next_ff;
   assign rsp_ring_value   = rsp_ring_ff;
   assign rsp_notify_queue = rsp_nq_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_last         = rsp_last_ff;

endmodule : virtqueue_descriptor_ring_manager

`default_nettype wire

### design/vdrm_checker.sv
// ----------------------------------------------------------------------------
// Descriptor ring manager port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vdrm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire  [2:0]                       rsp_kind,
   input wire  [7:0]                       rsp_slot,
   input wire  [7:0]                       rsp_free_count,
   input wire                              rsp_last
);

   import vdrm_pkg::*;

   // Output register is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_kind) && $stable(rsp_slot) &&
      $stable(rsp_last) && $stable(rsp_free_count))
      else $error("stalled result changed");

   // The avail write never ends an item; every non-descriptor result but it does
   a_last_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_AVAIL) && !rsp_last) ||
      ((rsp_kind == KIND_NOTIFY || rsp_kind == KIND_REJECT ||
        rsp_kind == KIND_DONE || rsp_kind == KIND_ERROR) && rsp_last) ||
      (rsp_kind == KIND_DESC))
      else $error("last flag inconsistent with result kind");

   // An avail write is always followed by its notify once transferred
   a_avail_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_kind == KIND_AVAIL) |=>
      !rsp_valid || (rsp_kind == KIND_NOTIFY))
      else $error("avail write not followed by notify");

endmodule : vdrm_checker

bind virtqueue_descriptor_ring_manager vdrm_checker u_vdrm_checker (.*);

`default_nettype wire

### verif/tb_virtqueue_descriptor_ring_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor ring manager testbench
// Drives start, segment and used-entry transfers through the ring manager and
// compares every result against an in-bench ring predictor. Covers the reject
// and error paths, the largest chain, output back-pressure and random traffic
// under several idling mixes.
// ----------------------------------------------------------------------------
module tb_virtqueue_descriptor_ring_manager;
   import vdrm_pkg::*;

   localparam int RING_SIZE = 256;
   localparam logic [1:0] MODE_ILLEGAL = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  slot;
      logic [63:0] address;
      logic [31:0] length;
      logic [1:0]  flags;
      logic [7:0]  next_slot;
      logic [7:0]  ring_value;
      logic [3:0]  notify_queue;
      logic [7:0]  free_count;
      logic        last;
   } ring_op_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_mode = MODE_START;
   logic [7:0]             req_segment_count = '0;
   logic [63:0]            req_buffer_address = '0;
   logic [31:0]            req_buffer_length = '0;
   logic [7:0]             req_used_id = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_kind;
   logic [7:0]             rsp_slot;
   logic [63:0]            rsp_desc_address;
   logic [31:0]            rsp_desc_length;
   logic [1:0]             rsp_desc_flags;
   logic [7:0]             rsp_next_slot;
   logic [7:0]             rsp_ring_value;
   logic [3:0]             rsp_notify_queue;
   logic [7:0]             rsp_free_count;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   // Predictor state
   logic [63:0] hdr_addr = '0;
   logic [3:0]  notify_id = '0;
   logic [7:0]  free_head = '0;
   logic [7:0]  reclaim_head = '0;
   logic [7:0]  free_slots = 8'(RING_SIZE - 2);
   logic [15:0] avail_idx = '0;
   logic [7:0]  chain_len [RING_SIZE];
   logic        chain_open = 1'b0;
   logic [7:0]  segs_left = '0;
   logic [7:0]  seg_pos = '0;

   ring_op_type ring_ops_due[$];
   int          mismatches = 0;
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   logic        stall_hold = 1'b0;

   virtqueue_descriptor_ring_manager #(.QUEUE_SIZE(RING_SIZE)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= stall_hold || ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic void queue_op(input logic [2:0] kind, input logic [7:0] slot,
                                    input logic [63:0] address, input logic [31:0] length,
                                    input logic [1:0] flags, input logic [7:0] next_slot,
                                    input logic [7:0] ring_value, input logic [3:0] nq,
                                    input logic last);
      ring_op_type op;
      op.kind = kind;
      op.slot = slot;
      op.address = address;
      op.length = length;
      op.flags = flags;
      op.next_slot = next_slot;
      op.ring_value = ring_value;
      op.notify_queue = nq;
      op.free_count = free_slots;
      op.last = last;
      ring_ops_due.push_back(op);
   endfunction

   function automatic void predict_ring_ops(input logic [1:0] mode, input logic [7:0] count,
                                            input logic [63:0] address,
                                            input logic [31:0] length, input logic [7:0] id);
      logic [7:0] desc;
      logic [7:0] head;
      logic [7:0] aslot;
      logic       tail_seg;
      int         span;
      case (mode)
         MODE_START: begin
            if (chain_open || count == 0 || int'(free_slots) < int'(count) + 1) begin
               queue_op(KIND_REJECT, 0, 0, 0, 0, 0, 0, 0, 1'b1);
            end else begin
               free_slots = 8'(int'(free_slots) - int'(count) - 1);
               chain_len[free_head] = count;
               chain_open = 1'b1;
               segs_left = count;
               seg_pos = '0;
               queue_op(KIND_DESC, free_head, hdr_addr, HEADER_SIZE, FLAG_NEXT,
                        8'((int'(free_head) + 1) % RING_SIZE), 0, 0, 1'b1);
            end
         end
         MODE_SEGMENT: begin
            if (!chain_open) begin
               queue_op(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1'b1);
            end else begin
               desc = 8'((int'(free_head) + int'(seg_pos) + 1) % RING_SIZE);
               tail_seg = (segs_left <= 1);
               queue_op(KIND_DESC, desc, address, length,
                        tail_seg ? FLAG_WRITE : (FLAG_WRITE | FLAG_NEXT),
                        8'((int'(desc) + 1) % RING_SIZE), 0, 0, !tail_seg);
               seg_pos = seg_pos + 8'd1;
               segs_left = segs_left - 8'd1;
               if (tail_seg) begin
                  // publish the chain: avail write then notify
                  head = free_head;
                  aslot = 8'(int'(avail_idx) % RING_SIZE);
                  free_head = 8'((int'(head) + int'(seg_pos) + 1) % RING_SIZE);
                  avail_idx = avail_idx + 16'd1;
                  chain_open = 1'b0;
                  segs_left = '0;
                  seg_pos = '0;
                  queue_op(KIND_AVAIL, aslot, 0, 0, 0, 0, head, 0, 1'b0);
                  queue_op(KIND_NOTIFY, 0, 0, 0, 0, 0, 0, notify_id, 1'b1);
               end
            end
         end
         MODE_USED: begin
            if (reclaim_head == free_head || id != reclaim_head) begin
               queue_op(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1'b1);
            end else begin
               head = reclaim_head;
               span = int'(chain_len[head]) + 1;
               free_slots = 8'(int'(free_slots) + span);
               reclaim_head = 8'((int'(head) + span) % RING_SIZE);
               queue_op(KIND_DONE, head, 0, 0, 0, 0, 0, 0, 1'b1);
            end
         end
         default: queue_op(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1'b1);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      ring_op_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_ops_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d slot %0h",
                     $time, rsp_kind, rsp_slot);
            mismatches++;
         end else begin
            want = ring_ops_due.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("slot", want.slot, rsp_slot);
            check_field("desc_address", want.address, rsp_desc_address);
            check_field("desc_length", want.length, rsp_desc_length);
            check_field("desc_flags", want.flags, rsp_desc_flags);
            check_field("next_slot", want.next_slot, rsp_next_slot);
            check_field("ring_value", want.ring_value, rsp_ring_value);
            check_field("notify_queue", want.notify_queue, rsp_notify_queue);
            check_field("free_count", want.free_count, rsp_free_count);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   function automatic logic [63:0] rand_addr();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] rand_len();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] rand_count();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 8'($urandom_range(1, 6));
      if (r < 92) return 8'($urandom_range(7, 40));
      if (r < 97) return 8'($urandom_range(255));
      return 8'd0;
   endfunction

   // Offer one transfer, hold it until taken, then predict its results.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] count,
                            input logic [63:0] address, input logic [31:0] length,
                            input logic [7:0] id);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_segment_count <= count;
      req_buffer_address <= address;
      req_buffer_length <= length;
      req_used_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_ring_ops(mode, count, address, length, id);
   endtask

   task automatic send_start(input logic [7:0] count);
      send_item(MODE_START, count, {$urandom, $urandom}, $urandom, 8'($urandom));
   endtask

   task automatic send_segment(input logic [63:0] address, input logic [31:0] length);
      send_item(MODE_SEGMENT, 8'($urandom), address, length, 8'($urandom));
   endtask

   task automatic send_used(input logic [7:0] id);
      send_item(MODE_USED, 8'($urandom), {$urandom, $urandom}, $urandom, id);
   endtask

   task automatic await_ring_idle();
      req_valid <= 1'b0;
      while (ring_ops_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_HEADER_ADDRESS: hdr_addr = data;
         CSR_QUEUE_ID:       notify_id = data[3:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_ring(input logic [63:0] header, input logic [63:0] qdata);
      write_csr(CSR_HEADER_ADDRESS, header);
      write_csr(CSR_QUEUE_ID, qdata);
   endtask

   task automatic run_traffic(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (chain_open) begin
            if (r < 88) send_segment(rand_addr(), rand_len());
            else if (r < 93) send_start(rand_count());
            else if (r < 97) send_used($urandom_range(1) ? reclaim_head : 8'($urandom));
            else send_item(MODE_ILLEGAL, 8'($urandom), rand_addr(), rand_len(), 8'($urandom));
         end else if (reclaim_head != free_head && (r < 40 || free_slots < 12)) begin
            send_used($urandom_range(9) == 0 ? 8'($urandom) : reclaim_head);
         end else if (r < 88) begin
            send_start(rand_count());
         end else if (r < 92) begin
            send_segment(rand_addr(), rand_len());
         end else if (r < 96) begin
            send_used(8'($urandom));
         end else begin
            send_item(MODE_ILLEGAL, 8'($urandom), rand_addr(), rand_len(), 8'($urandom));
         end
      end
      await_ring_idle();
   endtask

   task automatic test_directed();
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      send_segment(rand_addr(), rand_len());      // no open request
      send_used(8'd0);                            // nothing published
      send_item(MODE_ILLEGAL, '1, '1, '1, '1);
      send_start(8'd0);
      send_start(8'd255);
      send_start(8'd254);
      send_start(8'd2);
      send_start(8'd1);                           // request already open
      send_used(8'd0);                            // chain not yet published
      send_segment('1, '1);
      send_segment('0, '0);
      send_used(8'd5);                            // wrong head
      send_used(8'd0);
      send_used(8'd0);                            // already reclaimed
      await_ring_idle();
      program_ring('1, '1);
      write_csr(CSR_SPARE, {$urandom, $urandom});
      send_start(8'd1);
      send_segment(rand_addr(), rand_len());
      send_used(reclaim_head);
      await_ring_idle();
   endtask

   // Ring is empty here, so a 253-segment chain takes every free descriptor.
   task automatic test_largest_chain();
      send_gap_pct = 11;
      rsp_stall_pct = 11;
      program_ring({$urandom, $urandom}, {$urandom, $urandom});
      send_start(8'd253);
      repeat (253) send_segment(rand_addr(), rand_len());
      send_start(8'd1);
      send_used(reclaim_head);
      await_ring_idle();
   endtask

   task automatic test_backpressure();
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            stall_hold <= 1'b1;
            repeat (300) @(posedge clock);
            stall_hold <= 1'b0;
         end
      join_none
      repeat (8) begin
         send_start(8'd2);
         send_segment(rand_addr(), rand_len());
         send_segment(rand_addr(), rand_len());
         send_used(reclaim_head);
      end
      await_ring_idle();
   endtask

   task automatic test_random_mix();
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      program_ring('0, '0);
      run_traffic(26);
      send_gap_pct = 50;
      program_ring({$urandom, $urandom}, {$urandom, $urandom});
      run_traffic(26);
      send_gap_pct = 0;
      rsp_stall_pct = 50;
      program_ring('1, 64'hF);
      run_traffic(26);
      send_gap_pct = 11;
      rsp_stall_pct = 11;
      program_ring({$urandom, $urandom}, {$urandom, $urandom});
      run_traffic(26);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_largest_chain();
      test_backpressure();
      test_random_mix();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
